// ----- rtl/rmj_pkg.sv -----
package rmj_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W = 32;
	localparam int OUT_W = 32;
	localparam int DIV_W = 64;
	localparam int QUO_W = 32;
	localparam int X_QUO_W = 63;
	localparam int SQRT_STAGES = 64;
	localparam logic [IN_W-1:0] MIN_RANGE_RST = 32'd7;

	localparam logic [QUO_W:0] LIM_POS = {2'b00, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W:0] LIM_NEG = {2'b01, {(QUO_W-1){1'b0}}};

	typedef struct packed {
		logic signed [IN_W-1:0] pos_x;
		logic signed [IN_W-1:0] pos_y;
		logic signed [IN_W-1:0] vel_x;
		logic signed [IN_W-1:0] vel_y;
	} rmj_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] range_dpx;
		logic signed [OUT_W-1:0] range_dpy;
		logic signed [OUT_W-1:0] bearing_dpx;
		logic signed [OUT_W-1:0] bearing_dpy;
		logic signed [OUT_W-1:0] rate_dpx;
		logic signed [OUT_W-1:0] rate_dpy;
		logic singular;
		logic saturated;
	} rmj_out_t;

	typedef struct packed {
		logic sing;
		logic pneg;
		logic qneg;
		logic dneg;
		logic [IN_W-1:0] pm;
		logic [IN_W-1:0] qm;
		logic [DIV_W-1:0] c;
	} rmj_side_t;

	typedef struct packed {
		logic sing;
		logic pneg;
		logic qneg;
		logic dneg;
		logic xovf_p;
		logic xovf_q;
	} rmj_tail_t;

	typedef struct packed {
		logic [OUT_W-1:0] val;
		logic sat;
	} rmj_ent_t;

	function automatic rmj_ent_t rmj_finish(input logic ovf, input logic [QUO_W-1:0] quo,
			input logic [DIV_W-1:0] rem, input logic [DIV_W-1:0] den, input logic neg);
		logic up;
		logic [QUO_W:0] mag;
		logic [QUO_W:0] lim;
		logic [OUT_W-1:0] m;
		rmj_ent_t e;
		up = {rem, 1'b0} >= {1'b0, den};
		mag = {1'b0, quo} + {{QUO_W{1'b0}}, up};
		lim = neg ? LIM_NEG : LIM_POS;
		e.sat = 1'b0;
		if (ovf || mag > lim) begin
			e.sat = 1'b1;
			m = lim[OUT_W-1:0];
		end else begin
			m = mag[OUT_W-1:0];
		end
		e.val = neg ? (~m + 1'b1) : m;
		return e;
	endfunction

endpackage

// ----- rtl/rmj_div.sv -----
module rmj_div import rmj_pkg::*; #(
	parameter int NW = 96,
	parameter int K = QUO_W
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DIV_W-1:0] den,
	output logic [K-1:0] quo,
	output logic [DIV_W-1:0] rem,
	output logic [DIV_W-1:0] den_o,
	output logic ovf
);

	localparam int HW = NW - K;
	localparam int TW = (HW > DIV_W) ? HW : DIV_W;

	logic [TW-1:0] hi_ext;
	logic [TW-1:0] den_ext;
	logic [DIV_W-1:0] rem_s [K+1];
	logic [K-1:0] lo_s [K];
	logic [K-1:0] quo_s [K+1];
	logic [DIV_W-1:0] den_s [K+1];
	logic ovf_s [K+1];

	assign hi_ext = TW'(num[NW-1:K]);
	assign den_ext = TW'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_ext[DIV_W-1:0];
			lo_s[0] <= num[K-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= hi_ext >= den_ext;
		end
	end

	for (genvar k = 1; k <= K; k++) begin : g_step
		logic [DIV_W:0] t;
		logic [DIV_W:0] diff;
		logic ge;
		assign t = {rem_s[k-1], lo_s[k-1][K-1]};
		assign ge = t >= {1'b0, den_s[k-1]};
		assign diff = t - {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
				quo_s[k] <= {quo_s[k-1][K-2:0], ge};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
		if (k < K) begin : g_lo
			always_ff @(posedge clk) begin
				if (en) begin
					lo_s[k] <= lo_s[k-1] << 1;
				end
			end
		end
	end

	assign quo = quo_s[K];
	assign rem = rem_s[K];
	assign den_o = den_s[K];
	assign ovf = ovf_s[K];

endmodule

// ----- rtl/rmj_sqrt.sv -----
module rmj_sqrt import rmj_pkg::*; (
	input logic clk,
	input logic en,
	input logic [DIV_W-1:0] rad,
	output logic [DIV_W-1:0] root
);

	localparam int HALF = SQRT_STAGES / 2;
	localparam int RW = DIV_W + 2;

	logic [RW-1:0] rem_s [SQRT_STAGES-1];
	logic [DIV_W-1:0] root_s [SQRT_STAGES];
	logic [DIV_W-1:0] src_s [HALF-1];

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		logic [RW-1:0] prev_rem;
		logic [DIV_W-1:0] prev_root;
		logic [1:0] bring;
		logic [RW+1:0] t;
		logic [RW+1:0] trial;
		logic [RW+1:0] diff;
		logic ge;

		if (j == 0) begin : g_first
			assign prev_rem = '0;
			assign prev_root = '0;
		end else begin : g_next
			assign prev_rem = rem_s[j-1];
			assign prev_root = root_s[j-1];
		end

		if (j < HALF) begin : g_src
			logic [DIV_W-1:0] prev_src;
			if (j == 0) begin : g_src_first
				assign prev_src = rad;
			end else begin : g_src_next
				assign prev_src = src_s[j-1];
			end
			assign bring = prev_src[DIV_W-1 -: 2];
			if (j < HALF - 1) begin : g_src_keep
				always_ff @(posedge clk) begin
					if (en) begin
						src_s[j] <= prev_src << 2;
					end
				end
			end
		end else begin : g_zero
			assign bring = 2'b00;
		end

		assign t = {prev_rem, bring};
		assign trial = {2'b00, prev_root, 2'b01};
		assign ge = t >= trial;
		assign diff = t - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[j] <= {prev_root[DIV_W-2:0], ge};
			end
		end

		if (j < SQRT_STAGES - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? diff[RW-1:0] : t[RW-1:0];
				end
			end
		end
	end

	assign root = root_s[SQRT_STAGES-1];

endmodule

// ----- rtl/radar_measurement_jacobian_core.sv -----
// Radar measurement Jacobian for a two-dimensional constant-velocity state.
// The item channel (item_valid, item_stall, item_data) carries position and
// velocity in signed fixed point; the result channel (res_valid, res_stall,
// res_data) returns the six distinct Jacobian entries with singular and
// saturated flags. The cfg channel writes the minimum squared range and is
// always ready; it should be written only while no item is in flight.
// The datapath is a fixed pipeline: six front stages of multiplies and adds,
// a 64-stage square root running beside two 64-stage dividers, 33 divider
// stages for the final quotients, and the output register, 104 registers in
// all with the first loaded at the accepting edge. One item is taken every
// cycle while item_stall is low. When the receiver stalls, a result waits
// in the output register and one more lands in a skid register; item_stall
// then rises and the whole pipeline holds until the skid register drains.
// Reset empties the pipeline and loads the threshold with 7.
module radar_measurement_jacobian_core import rmj_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input rmj_in_t item_data,
	output logic res_valid,
	input logic res_stall,
	output rmj_out_t res_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [IN_W-1:0] cfg_data
);

	localparam int RNG_NW = 2 * IN_W + FRAC_BITS;
	localparam int BRG_NW = IN_W + 2 * FRAC_BITS;
	localparam int XN_W = 3 * IN_W + FRAC_BITS;
	localparam int RATE_NW = X_QUO_W + QUO_W;
	localparam int TAIL_N = QUO_W + 1;

	logic en;
	logic [IN_W-1:0] min_range_sq_q;

	rmj_in_t in_s1;
	logic vld_s1;

	logic signed [2*IN_W-1:0] pp_s2, qq_s2, a_s2, b_s2;
	logic [IN_W-1:0] pm_s2, qm_s2;
	logic pneg_s2, qneg_s2, vld_s2;

	logic [DIV_W-1:0] c_s3;
	logic signed [2*IN_W:0] diff_s3;
	logic [IN_W-1:0] pm_s3, qm_s3;
	logic pneg_s3, qneg_s3, vld_s3;

	logic [DIV_W-1:0] thr;
	rmj_side_t sd_s4, sd_s5, sd_s6;
	logic [DIV_W-1:0] dm_s4;
	logic vld_s4, vld_s5, vld_s6;
	logic [DIV_W-1:0] ql_s5, qh_s5, pl_s5, ph_s5;
	logic [3*IN_W-1:0] nq_s6, np_s6;

	rmj_side_t dla_s [SQRT_STAGES];
	logic dlav_s [SQRT_STAGES];
	rmj_side_t a_t;

	logic [DIV_W-1:0] s_root;
	logic [X_QUO_W-1:0] xq, xp;
	logic xovf_q, xovf_p;

	rmj_tail_t dlb_s [TAIL_N];
	logic dlbv_s [TAIL_N];
	rmj_tail_t b_t;

	logic [QUO_W-1:0] q_rpx, q_rpy, q_bpx, q_bpy, q_tpx, q_tpy;
	logic [DIV_W-1:0] r_rpx, r_rpy, r_bpx, r_bpy, r_tpx, r_tpy;
	logic [DIV_W-1:0] d_rpx, d_rpy, d_bpx, d_bpy, d_tpx, d_tpy;
	logic o_rpx, o_rpy, o_bpx, o_bpy, o_tpx, o_tpy;

	rmj_ent_t e_rpx, e_rpy, e_bpx, e_bpy, e_tpx, e_tpy;
	rmj_out_t res;
	logic res_vld;

	logic out_valid_q, skid_valid_q, take;
	rmj_out_t out_data_q, skid_data_q;

	assign en = !skid_valid_q;
	assign item_stall = skid_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_sq_q <= MIN_RANGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_range_sq_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign thr = DIV_W'({min_range_sq_q, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= item_data;

			pp_s2 <= in_s1.pos_x * in_s1.pos_x;
			qq_s2 <= in_s1.pos_y * in_s1.pos_y;
			a_s2 <= in_s1.vel_x * in_s1.pos_y;
			b_s2 <= in_s1.vel_y * in_s1.pos_x;
			pm_s2 <= in_s1.pos_x[IN_W-1] ? IN_W'(-in_s1.pos_x) : IN_W'(in_s1.pos_x);
			qm_s2 <= in_s1.pos_y[IN_W-1] ? IN_W'(-in_s1.pos_y) : IN_W'(in_s1.pos_y);
			pneg_s2 <= in_s1.pos_x[IN_W-1];
			qneg_s2 <= in_s1.pos_y[IN_W-1];

			c_s3 <= $unsigned(pp_s2 + qq_s2);
			diff_s3 <= (2*IN_W+1)'(a_s2) - (2*IN_W+1)'(b_s2);
			pm_s3 <= pm_s2;
			qm_s3 <= qm_s2;
			pneg_s3 <= pneg_s2;
			qneg_s3 <= qneg_s2;

			sd_s4.sing <= (c_s3 == '0) || (c_s3 < thr);
			sd_s4.pneg <= pneg_s3;
			sd_s4.qneg <= qneg_s3;
			sd_s4.dneg <= diff_s3[2*IN_W];
			sd_s4.pm <= pm_s3;
			sd_s4.qm <= qm_s3;
			sd_s4.c <= c_s3;
			dm_s4 <= diff_s3[2*IN_W] ? DIV_W'(-diff_s3) : DIV_W'(diff_s3);

			sd_s5 <= sd_s4;
			ql_s5 <= sd_s4.qm * dm_s4[IN_W-1:0];
			qh_s5 <= sd_s4.qm * dm_s4[DIV_W-1:IN_W];
			pl_s5 <= sd_s4.pm * dm_s4[IN_W-1:0];
			ph_s5 <= sd_s4.pm * dm_s4[DIV_W-1:IN_W];

			sd_s6 <= sd_s5;
			nq_s6 <= (3*IN_W)'(ql_s5) + {qh_s5, {IN_W{1'b0}}};
			np_s6 <= (3*IN_W)'(pl_s5) + {ph_s5, {IN_W{1'b0}}};
		end
	end

	rmj_sqrt u_sqrt (
		.clk(clk),
		.en(en),
		.rad(sd_s6.c),
		.root(s_root)
	);

	rmj_div #(.NW(XN_W), .K(X_QUO_W)) u_xdiv_q (
		.clk(clk),
		.en(en),
		.num({nq_s6, {FRAC_BITS{1'b0}}}),
		.den(sd_s6.c),
		.quo(xq),
		.rem(),
		.den_o(),
		.ovf(xovf_q)
	);

	rmj_div #(.NW(XN_W), .K(X_QUO_W)) u_xdiv_p (
		.clk(clk),
		.en(en),
		.num({np_s6, {FRAC_BITS{1'b0}}}),
		.den(sd_s6.c),
		.quo(xp),
		.rem(),
		.den_o(),
		.ovf(xovf_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQRT_STAGES; i++) begin
				dlav_s[i] <= 1'b0;
			end
		end else if (en) begin
			dlav_s[0] <= vld_s6;
			for (int i = 1; i < SQRT_STAGES; i++) begin
				dlav_s[i] <= dlav_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dla_s[0] <= sd_s6;
			for (int i = 1; i < SQRT_STAGES; i++) begin
				dla_s[i] <= dla_s[i-1];
			end
		end
	end

	assign a_t = dla_s[SQRT_STAGES-1];

	rmj_div #(.NW(RNG_NW), .K(QUO_W)) u_div_rpx (
		.clk(clk), .en(en),
		.num({a_t.pm, {(IN_W+FRAC_BITS){1'b0}}}), .den(s_root),
		.quo(q_rpx), .rem(r_rpx), .den_o(d_rpx), .ovf(o_rpx)
	);

	rmj_div #(.NW(RNG_NW), .K(QUO_W)) u_div_rpy (
		.clk(clk), .en(en),
		.num({a_t.qm, {(IN_W+FRAC_BITS){1'b0}}}), .den(s_root),
		.quo(q_rpy), .rem(r_rpy), .den_o(d_rpy), .ovf(o_rpy)
	);

	rmj_div #(.NW(BRG_NW), .K(QUO_W)) u_div_bpx (
		.clk(clk), .en(en),
		.num({a_t.qm, {(2*FRAC_BITS){1'b0}}}), .den(a_t.c),
		.quo(q_bpx), .rem(r_bpx), .den_o(d_bpx), .ovf(o_bpx)
	);

	rmj_div #(.NW(BRG_NW), .K(QUO_W)) u_div_bpy (
		.clk(clk), .en(en),
		.num({a_t.pm, {(2*FRAC_BITS){1'b0}}}), .den(a_t.c),
		.quo(q_bpy), .rem(r_bpy), .den_o(d_bpy), .ovf(o_bpy)
	);

	rmj_div #(.NW(RATE_NW), .K(QUO_W)) u_div_tpx (
		.clk(clk), .en(en),
		.num({xq, {QUO_W{1'b0}}}), .den(s_root),
		.quo(q_tpx), .rem(r_tpx), .den_o(d_tpx), .ovf(o_tpx)
	);

	rmj_div #(.NW(RATE_NW), .K(QUO_W)) u_div_tpy (
		.clk(clk), .en(en),
		.num({xp, {QUO_W{1'b0}}}), .den(s_root),
		.quo(q_tpy), .rem(r_tpy), .den_o(d_tpy), .ovf(o_tpy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAIL_N; i++) begin
				dlbv_s[i] <= 1'b0;
			end
		end else if (en) begin
			dlbv_s[0] <= dlav_s[SQRT_STAGES-1];
			for (int i = 1; i < TAIL_N; i++) begin
				dlbv_s[i] <= dlbv_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlb_s[0].sing <= a_t.sing;
			dlb_s[0].pneg <= a_t.pneg;
			dlb_s[0].qneg <= a_t.qneg;
			dlb_s[0].dneg <= a_t.dneg;
			dlb_s[0].xovf_p <= xovf_p;
			dlb_s[0].xovf_q <= xovf_q;
			for (int i = 1; i < TAIL_N; i++) begin
				dlb_s[i] <= dlb_s[i-1];
			end
		end
	end

	assign b_t = dlb_s[TAIL_N-1];
	assign res_vld = dlbv_s[TAIL_N-1];

	always_comb begin
		e_rpx = rmj_finish(o_rpx, q_rpx, r_rpx, d_rpx, b_t.pneg);
		e_rpy = rmj_finish(o_rpy, q_rpy, r_rpy, d_rpy, b_t.qneg);
		e_bpx = rmj_finish(o_bpx, q_bpx, r_bpx, d_bpx, !b_t.qneg);
		e_bpy = rmj_finish(o_bpy, q_bpy, r_bpy, d_bpy, b_t.pneg);
		e_tpx = rmj_finish(o_tpx || b_t.xovf_q, q_tpx, r_tpx, d_tpx,
			b_t.qneg != b_t.dneg);
		e_tpy = rmj_finish(o_tpy || b_t.xovf_p, q_tpy, r_tpy, d_tpy,
			b_t.pneg == b_t.dneg);
		if (b_t.sing) begin
			res = '0;
			res.singular = 1'b1;
		end else begin
			res.range_dpx = e_rpx.val;
			res.range_dpy = e_rpy.val;
			res.bearing_dpx = e_bpx.val;
			res.bearing_dpy = e_bpy.val;
			res.rate_dpx = e_tpx.val;
			res.rate_dpy = e_tpy.val;
			res.singular = 1'b0;
			res.saturated = e_rpx.sat | e_rpy.sat | e_bpx.sat | e_bpy.sat |
				e_tpx.sat | e_tpy.sat;
		end
	end

	assign take = out_valid_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_vld) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (res_vld) begin
			if (out_valid_q && !take) begin
				skid_data_q <= res;
			end else begin
				out_data_q <= res;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_data = out_data_q;

endmodule
